// ===== hw/rtl/cfct_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN frame change tracker package
// Shared widths, default sizes and the identifier mask.
// ----------------------------------------------------------------------------
package cfct_pkg;
  localparam int TableEntriesDefault   = 64;
  localparam int InterfaceCountDefault = 4;
  localparam logic [31:0] IdentMask = 32'h1FFF_FFFF;
  localparam int KeyW   = 31;
  localparam int AvgW   = 33;
  localparam int DataW  = 64;
  localparam int StampW = 32;
  localparam int TagW   = 32;
endpackage

// ===== hw/rtl/can_frame_change_tracker_top.sv =====
// ----------------------------------------------------------------------------
// CAN frame change tracker
// Tracks per-(interface, identifier) frames in a slot table and reports changes.
// ----------------------------------------------------------------------------
// The input channel carries one received frame per beat (interface, raw
// identifier, length, eight data bytes, timestamp). Each input beat gives
// exactly one result beat on the output channel. Both channels use
// valid/stall handshakes; a beat moves when valid is high and stall is low.
// The frame's key is searched by scanning the slot table, one slot per
// cycle, through a synchronous memory whose read data is registered. The
// scan visits every slot; S_READ then addresses the hit slot, S_WAIT reads
// it and S_UPD updates it and registers the result. The block takes no new
// frame until the output channel has taken the previous result, and the
// scan through the single memory read port sets the throughput. Frames
// whose interface index is out of range skip the scan and present their
// result in the cycle after acceptance.
// The result sits in an output register; while the receiver stalls it holds
// steady and no new frame is taken. Reset clears the slot valid bits, which
// are flip-flops, and the tag counter; the entry memory is not cleared since
// only the contents of valid slots are ever used. Reset needs no extra sweep.
// ----------------------------------------------------------------------------
module can_frame_change_tracker_top #(
  parameter int TABLE_ENTRIES   = cfct_pkg::TableEntriesDefault,
  parameter int INTERFACE_COUNT = cfct_pkg::InterfaceCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  interface_index,
  input  logic [31:0] raw_identifier,
  input  logic [3:0]  payload_length,
  input  logic [63:0] payload_bytes,
  input  logic [31:0] arrival_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        entry_is_new,
  output logic [7:0]  changed_bytes,
  output logic signed [32:0] interval_average,
  output logic [31:0] current_tag,
  output logic        notify,
  output logic        table_full
);
  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [28:0] IdentMaskLo = cfct_pkg::IdentMask[28:0];

  typedef struct packed {
    logic [cfct_pkg::KeyW-1:0]   key;
    logic [3:0]                  len;
    logic [cfct_pkg::DataW-1:0]  data;
    logic [cfct_pkg::StampW-1:0] stamp;
    logic [cfct_pkg::AvgW-1:0]   avg;
    logic [cfct_pkg::TagW-1:0]   tag;
    logic [7:0]                  mask;
  } entry_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_WAIT, S_UPD, S_OUT} state_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t          wr_data;

  logic [TABLE_ENTRIES-1:0] slot_valid;
  logic [cfct_pkg::TagW-1:0] tag_counter;
  state_t state;

  // Latched frame.
  logic [cfct_pkg::KeyW-1:0]   f_key;
  logic [3:0]                  f_len;
  logic [63:0]                 f_data;
  logic [31:0]                 f_stamp;

  // Scan state: the address counter runs one ahead of the returned data.
  logic [CntW-1:0] scan_cnt;
  logic [IdxW-1:0] chk_idx;
  logic            chk_vld;
  logic            found, have_free;
  logic [IdxW-1:0] hit, free_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign in_stall = (state != S_IDLE);

  // Comparison and update of the hit entry (from rd_data in S_UPD).
  logic [3:0] nb;
  logic [7:0] diff, len_mask, chg;
  logic       same;
  logic signed [33:0] sum;
  logic signed [33:0] half;
  logic [cfct_pkg::AvgW-1:0] avg_new;

  always_comb begin
    nb = (f_len > 4'd8) ? 4'd8 : f_len;
    for (int i = 0; i < 8; i++) begin
      diff[i] = (i < nb) && (f_data[8*i +: 8] != rd_data.data[8*i +: 8]);
      len_mask[i] = (i < nb);
    end
    same = (rd_data.len == f_len) && (diff == 8'd0);
    chg  = (rd_data.len != f_len) ? len_mask : diff;
    sum  = $signed({2'b00, f_stamp}) - $signed({2'b00, rd_data.stamp})
         + $signed({rd_data.avg[32], rd_data.avg});
    half = (sum + $signed({33'd0, sum[33]})) >>> 1;
    avg_new = half[32:0];
  end

  logic key_match;
  assign key_match = (rd_data.key == f_key);

  always_comb begin
    rd_addr = (state == S_SCAN) ? scan_cnt[IdxW-1:0] : hit;
    wr_en   = 1'b0;
    wr_addr = hit;
    wr_data = rd_data;
    if (state == S_UPD && found) begin
      wr_en = 1'b1;
      wr_data.stamp = f_stamp;
      wr_data.avg   = avg_new;
      if (!same) begin
        wr_data.len  = f_len;
        wr_data.data = f_data;
        wr_data.tag  = tag_counter + 32'd1;
        wr_data.mask = chg;
      end
    end else if (state == S_UPD && have_free) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = '{key: f_key, len: f_len, data: f_data, stamp: f_stamp,
                  avg: '0, tag: tag_counter + 32'd1, mask: 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      tag_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            f_key   <= {interface_index, raw_identifier[28:0] & IdentMaskLo};
            f_len   <= payload_length;
            f_data  <= payload_bytes;
            f_stamp <= arrival_stamp;
            found <= 1'b0; have_free <= 1'b0;
            scan_cnt <= '0; chk_vld <= 1'b0;
            if ({30'd0, interface_index} < INTERFACE_COUNT) begin
              state <= S_SCAN;
            end else begin
              entry_is_new <= 1'b0; changed_bytes <= '0; interval_average <= '0;
              current_tag <= tag_counter; notify <= 1'b0; table_full <= 1'b0;
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (chk_vld) begin
            if (slot_valid[chk_idx]) begin
              if (!found && key_match) begin found <= 1'b1; hit <= chk_idx; end
            end else if (!have_free) begin
              have_free <= 1'b1; free_idx <= chk_idx;
            end
          end
          if (scan_cnt == CntW'(TABLE_ENTRIES)) begin
            chk_vld <= 1'b0;
            state   <= S_READ;
          end else begin
            chk_idx  <= scan_cnt[IdxW-1:0];
            chk_vld  <= 1'b1;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_READ: state <= S_WAIT;   // rd_addr now holds hit
        S_WAIT: state <= S_UPD;
        S_UPD: begin
          // A hit updates the entry; a miss takes the free slot or reports full.
          entry_is_new     <= !found && have_free;
          changed_bytes    <= (found && !same) ? chg : 8'd0;
          interval_average <= found ? avg_new : '0;
          notify           <= found ? (!same && (chg != 8'd0)) : have_free;
          table_full       <= !found && !have_free;
          if (found ? !same : have_free) begin
            tag_counter <= tag_counter + 32'd1;
            current_tag <= tag_counter + 32'd1;
          end else begin
            current_tag <= tag_counter;
          end
          if (!found && have_free) begin
            slot_valid[free_idx] <= 1'b1;
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/cfct_checker.sv =====
// ----------------------------------------------------------------------------
// CAN frame change tracker port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module cfct_port_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        entry_is_new,
  input logic [7:0]  changed_bytes,
  input logic [31:0] current_tag,
  input logic        notify,
  input logic        table_full
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(current_tag))
    else $error("stalled result changed");
  a_notify: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> notify == (entry_is_new || changed_bytes != 8'd0))
    else $error("notify mismatch");
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !entry_is_new && changed_bytes == 8'd0)
    else $error("full result carries data");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
endmodule

bind can_frame_change_tracker_top cfct_port_props u_cfct_port_props (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .entry_is_new(entry_is_new),
  .changed_bytes(changed_bytes), .current_tag(current_tag), .notify(notify),
  .table_full(table_full)
);

// ===== verif/cfct_checker.sv =====
// ----------------------------------------------------------------------------
// CAN frame change tracker checker
// Watches both channels, predicts each result beat from the accepted frames
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module cfct_checker #(
  parameter int TABLE_ENTRIES   = cfct_pkg::TableEntriesDefault,
  parameter int INTERFACE_COUNT = cfct_pkg::InterfaceCountDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         interface_index,
  input  logic [31:0]        raw_identifier,
  input  logic [3:0]         payload_length,
  input  logic [63:0]        payload_bytes,
  input  logic [31:0]        arrival_stamp,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               entry_is_new,
  input  logic [7:0]         changed_bytes,
  input  logic signed [32:0] interval_average,
  input  logic [31:0]        current_tag,
  input  logic               notify,
  input  logic               table_full,
  output int                 failures,
  output int                 pending
);
  typedef struct packed {
    logic              is_new;
    logic [7:0]        changed;
    logic signed [32:0] avg;
    logic [31:0]       tag;
    logic              notify;
    logic              full;
  } tracker_result_t;

  logic                         entry_used [TABLE_ENTRIES];
  logic [cfct_pkg::KeyW-1:0]    entry_key  [TABLE_ENTRIES];
  logic [3:0]                   entry_len  [TABLE_ENTRIES];
  logic [cfct_pkg::DataW-1:0]   entry_data [TABLE_ENTRIES];
  logic [cfct_pkg::StampW-1:0]  entry_stamp[TABLE_ENTRIES];
  logic signed [cfct_pkg::AvgW-1:0] entry_avg[TABLE_ENTRIES];
  logic [cfct_pkg::TagW-1:0]    change_tag;
  tracker_result_t              expected_results[$];

  function automatic tracker_result_t track_frame(logic [1:0] ifc, logic [31:0] rid,
      logic [3:0] len, logic [63:0] data, logic [31:0] stamp);
    tracker_result_t r;
    logic [cfct_pkg::KeyW-1:0] key;
    int hit, free_slot, nb;
    logic [7:0] diff;
    logic signed [34:0] sum;
    r = '0;
    hit = -1;
    free_slot = -1;
    diff = '0;
    key = {ifc, rid[28:0] & cfct_pkg::IdentMask[28:0]};
    nb = (len > 8) ? 8 : int'(len);
    if (ifc < INTERFACE_COUNT) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (entry_used[i]) begin
          if (hit < 0 && entry_key[i] == key) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit >= 0) begin
        for (int i = 0; i < nb; i++)
          if (data[8*i +: 8] != entry_data[hit][8*i +: 8]) diff[i] = 1'b1;
        // Delta is a signed 33-bit difference; halve the sum toward zero.
        sum = $signed({3'b0, stamp}) - $signed({3'b0, entry_stamp[hit]})
              + 35'(entry_avg[hit]);
        r.avg = 33'((sum < 0) ? -((-sum) >>> 1) : (sum >>> 1));
        entry_stamp[hit] = stamp;
        entry_avg[hit] = r.avg;
        if (entry_len[hit] != len || diff != 0) begin
          r.changed = (entry_len[hit] != len) ? 8'((9'd1 << nb) - 1) : diff;
          entry_len[hit] = len;
          entry_data[hit] = data;
          change_tag++;
        end
      end else if (free_slot >= 0) begin
        change_tag++;
        entry_used[free_slot] = 1'b1;
        entry_key[free_slot] = key;
        entry_len[free_slot] = len;
        entry_data[free_slot] = data;
        entry_stamp[free_slot] = stamp;
        entry_avg[free_slot] = '0;
        r.is_new = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end
    r.tag = change_tag;
    r.notify = r.is_new || (r.changed != 0);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    tracker_result_t want, got, fresh;
    if (rst) begin
      foreach (entry_used[i]) entry_used[i] = 1'b0;
      change_tag = '0;
      expected_results.delete();
      failures <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        fresh = track_frame(interface_index, raw_identifier, payload_length,
                            payload_bytes, arrival_stamp);
        expected_results = {expected_results, fresh};
      end
      if (out_valid && !out_stall) begin
        got = '{entry_is_new, changed_bytes, interval_average, current_tag, notify,
                table_full};
        if (expected_results.size() == 0) begin
          failures <= failures + 1;
          if (failures < 10) $display("Unexpected result beat: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            failures <= failures + 1;
            if (failures < 10) $display("Mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// CAN frame change tracker testbench
// Drives directed and random frames under varied idling and back pressure,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0]  interface_index;
  logic [31:0] raw_identifier, arrival_stamp, current_tag;
  logic [3:0]  payload_length;
  logic [63:0] payload_bytes;
  logic entry_is_new, notify, table_full;
  logic [7:0] changed_bytes;
  logic signed [32:0] interval_average;
  int failures, pending;
  int send_idle_pct, stall_pct;
  logic hold_req;
  logic hold_used;
  int hold_left;
  int quiet_cycles;
  logic [31:0] stamp_now;
  // A small pool of keys so that most frames hit existing entries.
  logic [31:0] key_pool[16];

  can_frame_change_tracker_top dut (.*);
  cfct_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at the current rate, or holds off completely once
  // for a long stretch, counted down here, when the stimulus asks for it.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= 2000;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // A watchdog: too long without any beat moving ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One beat: optional idle cycles first, then hold valid until accepted.
  task automatic send_frame(logic [1:0] ifc, logic [31:0] rid, logic [3:0] len,
                            logic [63:0] data, logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    interface_index <= ifc;
    raw_identifier <= rid;
    payload_length <= len;
    payload_bytes <= data;
    arrival_stamp <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_frame();
    logic [31:0] rid;
    logic [3:0] len;
    logic [63:0] data;
    rid = key_pool[$urandom_range(15)];
    if ($urandom_range(9) == 0) rid = $urandom;
    len = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    data = {$urandom, $urandom};
    // Often resend the same bytes, or change only one, to exercise the unchanged path.
    if ($urandom_range(2) != 0) data = 64'(payload_bytes ^ ($urandom_range(1) ?
        64'(0) : (64'hFF << (8 * $urandom_range(7)))));
    if ($urandom_range(7) == 0) stamp_now = $urandom;
    else stamp_now = stamp_now + $urandom_range(5000);
    send_frame(2'($urandom_range(3)), rid, len, data, stamp_now);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    interface_index = 0;
    raw_identifier = 0;
    payload_length = 0;
    payload_bytes = 0;
    arrival_stamp = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    stamp_now = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: new entry, same frame, byte change, length change, length 0,
    // length above eight, stamp going backward and flag bits outside the key.
    send_frame(0, 32'h0, 8, 64'h0, 32'h0);
    send_frame(0, 32'hE000_0000, 8, 64'h0, 32'hFFFF_FFFF);
    send_frame(0, 32'h0, 8, 64'hFF00_0000_0000_00FF, 32'h0);
    send_frame(0, 32'h0, 3, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send_frame(0, 32'h0, 3, 64'h1234_5678_FFFF_FFFF, 32'h7FFF_FFFF);
    send_frame(0, 32'h0, 0, 64'h0, 32'h0);
    send_frame(0, 32'h0, 15, 64'hA5A5_A5A5_A5A5_A5A5, 32'h1);
    send_frame(0, 32'h0, 15, 64'hA5A5_A5A5_A5A5_A5A4, 32'hFFFF_FFFF);
    send_frame(3, 32'h1FFF_FFFF, 8, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(3, 32'h1FFF_FFFF, 8, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_frame(1, 32'h5555_5555, 4, 64'h5555_5555_5555_5555, 32'h5555_5555);
    send_frame(2, 32'hAAAA_AAAA, 4, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    drain();

    // Random phases with different idle and stall rates.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 52 : 33) : 0;
      stall_pct = (ph == 2) ? 52 : (ph == 3 ? 33 : 0);
      if (ph == 2) hold_req = 1;
      repeat (150) random_frame();
    end
    drain();

    // Send more fresh keys than the table holds so that it reports full, then reuse old keys.
    send_idle_pct = 10;
    stall_pct = 10;
    repeat (80) send_frame(2'($urandom_range(3)), $urandom, 4'($urandom_range(8)),
                           {$urandom, $urandom}, $urandom);
    repeat (60) random_frame();
    drain();

    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
